>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and payload types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ADDR_W    = $clog2(CELL_COUNT);
  localparam int POS_W     = $clog2(CELL_COUNT + 1);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int COL_SUM_W = COL_W + 1;
  localparam int TAB_W     = $clog2(TAB_STOP);
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;

  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 9;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELL_COUNT - COLUMNS);

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS     = 9'd8;
  localparam logic [CHAR_W-1:0] CH_TAB    = 9'd9;
  localparam logic [CHAR_W-1:0] CH_LF     = 9'd10;
  localparam logic [CHAR_W-1:0] CH_CR     = 9'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 9'h020;
  localparam logic [CHAR_W-1:0] CH_BS_ALT = 9'h100;

  localparam logic [7:0]        BLANK_CHAR = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } in_req_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   cell_value;
    logic                scrolled;
  } out_res_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

endpackage

>>> rtl/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_cell_ram (
  input  logic                          clk,
  input  tcw_pkg::ram_req_t             req,
  output logic [tcw_pkg::CELL_W-1:0]    rd_data
);

  logic [tcw_pkg::CELL_W-1:0] cells_r [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      cells_r[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= cells_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/tcw_seq.sv
// ----------------------------------------------------------------------------
// tcw_seq
// Request sequencer: cursor update, cell write and read, scroll and fill sweeps.
// ----------------------------------------------------------------------------
module tcw_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tcw_pkg::in_req_t            in_req,
  input  logic [tcw_pkg::ATTR_W-1:0]  attr,
  input  logic                        out_free,
  output logic                        res_load,
  output tcw_pkg::out_res_t           res,
  output tcw_pkg::ram_req_t           ram,
  input  logic [tcw_pkg::CELL_W-1:0]  ram_rd_data
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                        state_r, state_nxt;
  tcw_pkg::in_req_t                  req_r, req_nxt;
  logic [tcw_pkg::POS_W-1:0]         cursor_r, cursor_nxt;
  logic [tcw_pkg::COL_W-1:0]         col_r, col_nxt;
  logic [tcw_pkg::ADDR_W-1:0]        cnt_r, cnt_nxt;
  logic                              scrl_r, scrl_nxt;
  logic                              hit_r, hit_nxt;

  logic [tcw_pkg::CELL_W-1:0]        blank;
  logic [tcw_pkg::POS_W-1:0]         tab_step;
  logic [tcw_pkg::COL_SUM_W-1:0]     tab_col;
  logic [tcw_pkg::POS_W-1:0]         put_cur;
  logic [tcw_pkg::COL_W-1:0]         put_col;
  logic                              put_wr;
  logic [tcw_pkg::ADDR_W-1:0]        put_addr;
  logic [tcw_pkg::CELL_W-1:0]        put_cell;
  logic                              need_scroll;
  logic [tcw_pkg::POS_W-1:0]         fin_cur;
  logic                              rd_hit;

  assign blank  = {attr, tcw_pkg::BLANK_CHAR};
  assign rd_hit = req_r.cell_index < tcw_pkg::INDEX_W'(tcw_pkg::CELL_COUNT);

  always_comb begin
    tab_step = tcw_pkg::POS_W'(tcw_pkg::TAB_STOP)
             - tcw_pkg::POS_W'(cursor_r[tcw_pkg::TAB_W-1:0]);
    tab_col  = tcw_pkg::COL_SUM_W'(col_r) + tcw_pkg::COL_SUM_W'(tab_step);
    put_cur  = cursor_r;
    put_col  = col_r;
    put_wr   = 1'b0;
    put_cell = blank;
    case (req_r.char_code) inside
      tcw_pkg::CH_LF: begin
        put_cur = cursor_r + (tcw_pkg::POS_W'(tcw_pkg::COLUMNS) - tcw_pkg::POS_W'(col_r));
        put_col = '0;
      end
      tcw_pkg::CH_BS, tcw_pkg::CH_BS_ALT: begin
        put_wr = 1'b1;
        if (cursor_r != '0) begin
          put_cur = cursor_r - tcw_pkg::POS_W'(1);
          put_col = (col_r == '0) ? tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)
                                  : col_r - tcw_pkg::COL_W'(1);
        end
      end
      tcw_pkg::CH_TAB: begin
        put_cur = cursor_r + tab_step;
        put_col = (tab_col >= tcw_pkg::COL_SUM_W'(tcw_pkg::COLUMNS))
                ? tcw_pkg::COL_W'(tab_col - tcw_pkg::COL_SUM_W'(tcw_pkg::COLUMNS))
                : tcw_pkg::COL_W'(tab_col);
      end
      tcw_pkg::CH_CR: begin
        put_cur = cursor_r - tcw_pkg::POS_W'(col_r);
        put_col = '0;
      end
      default: begin
        if (req_r.char_code >= tcw_pkg::CH_SPACE) begin
          put_wr   = 1'b1;
          put_cell = {attr, req_r.char_code[7:0]};
          put_cur  = cursor_r + tcw_pkg::POS_W'(1);
          put_col  = (col_r == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1))
                   ? '0 : col_r + tcw_pkg::COL_W'(1);
        end
      end
    endcase
    put_addr    = tcw_pkg::ADDR_W'(put_wr && (req_r.char_code != tcw_pkg::CH_BS)
                  && (req_r.char_code != tcw_pkg::CH_BS_ALT) ? cursor_r : put_cur);
    need_scroll = put_cur >= tcw_pkg::POS_W'(tcw_pkg::CELL_COUNT);
    fin_cur     = need_scroll ? put_cur - tcw_pkg::POS_W'(tcw_pkg::COLUMNS) : put_cur;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    cnt_nxt    = cnt_r;
    scrl_nxt   = scrl_r;
    hit_nxt    = hit_r;
    ram        = '0;
    res_load   = 1'b0;
    res.cursor_pos = tcw_pkg::CURSOR_W'(cursor_r);
    res.cell_value = '0;
    res.scrolled   = scrl_r;
    in_stall   = (state_r != S_IDLE);
    unique case (state_r)
      S_INIT: begin
        ram.wr_en   = 1'b1;
        ram.wr_addr = cnt_r;
        ram.wr_data = tcw_pkg::RESET_CELL;
        if (cnt_r == tcw_pkg::LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + tcw_pkg::ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_r.func)
          tcw_pkg::FUNC_PUT: begin
            if (need_scroll || out_free) begin
              ram.wr_en   = put_wr;
              ram.wr_addr = put_addr;
              ram.wr_data = put_cell;
              cursor_nxt  = fin_cur;
              col_nxt     = put_col;
              scrl_nxt    = need_scroll;
              if (need_scroll) begin
                cnt_nxt   = '0;
                state_nxt = S_SCROLL;
              end else begin
                res_load       = 1'b1;
                res.cursor_pos = tcw_pkg::CURSOR_W'(fin_cur);
                res.scrolled   = 1'b0;
                state_nxt      = S_IDLE;
              end
            end
          end
          tcw_pkg::FUNC_CLEAR: begin
            cursor_nxt = '0;
            col_nxt    = '0;
            scrl_nxt   = 1'b0;
            cnt_nxt    = '0;
            state_nxt  = S_FILL;
          end
          tcw_pkg::FUNC_READ: begin
            hit_nxt     = rd_hit;
            ram.rd_en   = rd_hit;
            ram.rd_addr = tcw_pkg::ADDR_W'(req_r.cell_index);
            state_nxt   = S_READ;
          end
          default: begin
            if (out_free) begin
              res_load     = 1'b1;
              res.scrolled = 1'b0;
              state_nxt    = S_IDLE;
            end
          end
        endcase
      end
      S_SCROLL: begin
        if (cnt_r != tcw_pkg::SCROLL_END) begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = cnt_r + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        end
        if (cnt_r != '0) begin
          ram.wr_en   = 1'b1;
          ram.wr_addr = cnt_r - tcw_pkg::ADDR_W'(1);
          ram.wr_data = ram_rd_data;
        end
        if (cnt_r == tcw_pkg::SCROLL_END) begin
          state_nxt = S_FILL;
        end else begin
          cnt_nxt = cnt_r + tcw_pkg::ADDR_W'(1);
        end
      end
      S_FILL: begin
        ram.wr_en   = 1'b1;
        ram.wr_addr = cnt_r;
        ram.wr_data = blank;
        if (cnt_r == tcw_pkg::LAST_CELL) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + tcw_pkg::ADDR_W'(1);
        end
      end
      S_READ: begin
        if (out_free) begin
          res_load       = 1'b1;
          res.cell_value = hit_r ? ram_rd_data : '0;
          res.scrolled   = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      cursor_r <= '0;
      col_r    <= '0;
      cnt_r    <= '0;
      scrl_r   <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
      cnt_r    <= cnt_nxt;
      scrl_r   <= scrl_nxt;
      hit_r    <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result loaded while output register is blocked");

  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> state_r == S_IDLE)
    else $error("sequencer not idle after result");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r < tcw_pkg::POS_W'(tcw_pkg::CELL_COUNT) && col_r < tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
    else $error("cursor out of range");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !ram.wr_en && !ram.rd_en)
    else $error("memory access while idle");

endmodule

>>> rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console writer: 80x25 cell buffer with cursor, put/clear/read requests.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one request: put a
// character, clear the screen and home the cursor, or read one cell.
// Output channel out_valid/out_stall/out_data returns exactly one result per
// request: the cursor position, the cell value for a read, and a scroll flag.
// cfg_wr_en/cfg_wr_data set the attribute byte used for printed and blank
// cells; write it only while no request is in flight.
// A put that scrolls moves the rows up by one and then blanks the last row,
// one cell moved or blanked a cycle; a clear blanks every cell the same way.
// A put without scroll, a read and an unused func need no sweep.
// After reset the memory is filled with blank cells (0x0F20), one cell a
// cycle; in_stall stays high until every cell is written.
// The result sits in an output register; while out_stall is high it holds
// and the next request is still accepted; a put that scrolls, a read and a
// clear are executed up to their result, while a put without scroll waits
// before it writes or moves the cursor.
// ----------------------------------------------------------------------------
module text_console_writer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tcw_pkg::in_req_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tcw_pkg::out_res_t           out_data,
  input  logic                        cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wr_data
);

  logic [tcw_pkg::ATTR_W-1:0]  attr_r;
  logic                        out_valid_r;
  tcw_pkg::out_res_t           out_res_r;
  logic                        out_free;
  logic                        res_load;
  tcw_pkg::out_res_t           res;
  tcw_pkg::ram_req_t           ram;
  logic [tcw_pkg::CELL_W-1:0]  ram_rd_data;

  assign out_free = !out_valid_r || !out_stall;

  tcw_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_data),
    .attr        (attr_r),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res),
    .ram         (ram),
    .ram_rd_data (ram_rd_data)
  );

  tcw_cell_ram u_ram (
    .clk     (clk),
    .req     (ram),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      attr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_res_r;

endmodule
